// ----- rtl/eotq_pkg.sv -----
// Types and constants shared by the expiry-ordered timer queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package eotq_pkg;

  localparam int TIME_W      = 63;
  localparam int IDENT_W     = 8;
  localparam int MIN_W       = 30;
  localparam int SEC_W       = 34;
  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);
  localparam int RIDX_W      = $clog2(MAX_RESULTS);

  localparam logic [TIME_W-1:0] NS_PER_SEC  = TIME_W'(1000 * 1000 * 1000);
  // floor(2^61 / 10^9): reciprocal of one second for the top 34 bits of a delay
  localparam logic [31:0]       SEC_RECIP   = 32'd2305843009;
  localparam logic [TIME_W-1:0] TIME_MAX    = {TIME_W{1'b1}};
  localparam logic [MIN_W-1:0]  MIN_DEFAULT = MIN_W'(100000);

  typedef enum logic [1:0] {
    RC_NONE  = 2'd0,
    RC_FIRED = 2'd1,
    RC_ADDED = 2'd2,
    RC_FULL  = 2'd3
  } result_code_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2,
    CELL_CLEAR  = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic                fresh;
    logic [TIME_W-1:0]   expire;
    logic [TIME_W-1:0]   interval;
    logic [IDENT_W-1:0]  ident;
  } entry_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   entry;
  } cell_ctrl_t;

  typedef struct packed {
    result_code_t       code;
    logic [IDENT_W-1:0] ident;
    logic               rearm;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/eotq_if.sv -----
// Request and response channel interfaces of the timer queue.
// Depends on eotq_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface eotq_req_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [eotq_pkg::TIME_W-1:0]    now_time;
  logic [eotq_pkg::TIME_W-1:0]    expire_time;
  logic [eotq_pkg::TIME_W-1:0]    repeat_interval;
  logic [eotq_pkg::IDENT_W-1:0]   timer_ident;
  modport source (output valid, kind, now_time, expire_time, repeat_interval, timer_ident,
                  input ready);
  modport sink (input valid, kind, now_time, expire_time, repeat_interval, timer_ident,
                output ready);
endinterface

interface eotq_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     result_code;
  logic [eotq_pkg::IDENT_W-1:0]   fired_ident;
  logic                           was_rearmed;
  logic                           queue_empty;
  logic [eotq_pkg::SEC_W-1:0]     delay_sec;
  logic [eotq_pkg::MIN_W-1:0]     delay_nsec;
  logic                           last;
  modport source (output valid, result_code, fired_ident, was_rearmed, queue_empty,
                  delay_sec, delay_nsec, last, input ready);
  modport sink (input valid, result_code, fired_ident, was_rearmed, queue_empty,
                delay_sec, delay_nsec, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/eotq_cell.sv -----
// One slot of the sorted timer chain; trades entries with its neighbours.
// Depends on eotq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module eotq_cell (
  input  wire                       clk,
  input  wire eotq_pkg::cell_ctrl_t ctrl,
  input  wire                       occ,
  input  wire eotq_pkg::entry_t     left_data,
  input  wire                       left_after,
  input  wire eotq_pkg::entry_t     right_data,
  output eotq_pkg::entry_t          data,
  output logic                      after
);

  assign after = !occ || (data.expire > ctrl.entry.expire);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      eotq_pkg::CELL_INSERT: begin
        if (after) data <= left_after ? left_data : ctrl.entry;
      end
      eotq_pkg::CELL_POP:   data <= right_data;
      eotq_pkg::CELL_CLEAR: data.fresh <= 1'b0;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/eotq_divider.sv -----
// Splits a delay into seconds and nanoseconds: reciprocal multiply, remainder, correction.
// Depends on eotq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module eotq_divider (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  input  wire [eotq_pkg::TIME_W-1:0]  dividend,
  output logic                        done,
  output logic [eotq_pkg::SEC_W-1:0]  quot,
  output logic [eotq_pkg::MIN_W-1:0]  rem_out
);

  localparam int          SHIFT   = eotq_pkg::TIME_W - eotq_pkg::SEC_W;
  localparam logic [31:0] ONE_SEC = 32'(eotq_pkg::NS_PER_SEC);
  localparam logic [31:0] TWO_SEC = ONE_SEC << 1;

  logic [eotq_pkg::SEC_W-1:0] top_bits;
  logic [31:0]                low_bits;
  logic [eotq_pkg::SEC_W-1:0] q_est;
  logic [31:0]                r_est;
  logic                       stage_a;
  logic                       stage_b;
  logic                       stage_c;
  logic [63:0]                prod_lo;
  logic [eotq_pkg::SEC_W-1:0] prod_hi;
  logic [31:0]                q_ns;
  logic [31:0]                r_less1;
  logic [31:0]                r_less2;

  // estimate falls short of the quotient by at most two
  assign prod_lo = {32'd0, top_bits[31:0]} * {32'd0, eotq_pkg::SEC_RECIP};
  assign prod_hi = {{(eotq_pkg::SEC_W-2){1'b0}}, top_bits[eotq_pkg::SEC_W-1:32]} *
                   {{(eotq_pkg::SEC_W-32){1'b0}}, eotq_pkg::SEC_RECIP};
  assign q_ns    = q_est[31:0] * ONE_SEC;
  assign r_less1 = r_est - ONE_SEC;
  assign r_less2 = r_est - TWO_SEC;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_a <= 1'b0;
      stage_b <= 1'b0;
      stage_c <= 1'b0;
      done    <= 1'b0;
    end else begin
      stage_a <= start;
      stage_b <= stage_a;
      stage_c <= stage_b;
      done    <= stage_c;
      if (start) begin
        top_bits <= dividend[eotq_pkg::TIME_W-1:SHIFT];
        low_bits <= dividend[31:0];
      end
      if (stage_a) begin
        q_est <= {{(eotq_pkg::SEC_W-32){1'b0}}, prod_lo[63:32]} + prod_hi;
      end
      if (stage_b) begin
        r_est <= low_bits - q_ns;
      end
      if (stage_c) begin
        if (r_est >= TWO_SEC) begin
          quot    <= q_est + eotq_pkg::SEC_W'(2);
          rem_out <= r_less2[eotq_pkg::MIN_W-1:0];
        end else if (r_est >= ONE_SEC) begin
          quot    <= q_est + eotq_pkg::SEC_W'(1);
          rem_out <= r_less1[eotq_pkg::MIN_W-1:0];
        end else begin
          quot    <= q_est;
          rem_out <= r_est[eotq_pkg::MIN_W-1:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/expiry_ordered_timer_queue.sv -----
// Top level of the expiry-ordered timer queue: cell chain, walk sequencer, output.
// Depends on eotq_pkg, eotq_if, eotq_cell and eotq_divider.
`timescale 1ns / 1ps
`default_nettype none
// Timers sit in a chain of CAPACITY cells kept sorted by expiration; an add is inserted as
// it is accepted, and a tick pops one due timer per cycle and pauses in a re-arm step for
// each re-armed timer. Results of an item are gathered first, then the delay to the next
// expiration is split into seconds and nanoseconds by a three-stage reciprocal multiply
// with a final correction; when the table ends empty the split is skipped. Further results
// follow the first as the receiver takes them.
// A new word is taken once the last result sits in the output register.
module expiry_ordered_timer_queue #(
  parameter int CAPACITY = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire [eotq_pkg::MIN_W-1:0]    cfg_data,
  eotq_req_if.sink                     req,
  eotq_rsp_if.source                   rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WALK  = 6'b000010,
    S_REARM = 6'b000100,
    S_DPREP = 6'b001000,
    S_DIV   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t                         state;
  logic [CNT_W-1:0]               count;
  logic [eotq_pkg::MIN_W-1:0]     min_delay;
  logic [eotq_pkg::TIME_W-1:0]    now_reg;
  eotq_pkg::entry_t               rearm_entry;
  eotq_pkg::res_t                 res_buf [eotq_pkg::MAX_RESULTS];
  logic [eotq_pkg::RES_W-1:0]     nres;
  logic [eotq_pkg::RES_W-1:0]     emit_idx;
  logic                           empty_reg;
  logic [eotq_pkg::SEC_W-1:0]     sec_reg;
  logic [eotq_pkg::MIN_W-1:0]     nsec_reg;

  eotq_pkg::cell_ctrl_t           ctrl;
  eotq_pkg::entry_t               cell_data [CAPACITY];
  logic [CAPACITY-1:0]            cell_after;

  logic                           accept;
  logic                           full;
  logic                           head_due;
  logic                           can_fire;
  logic [eotq_pkg::TIME_W:0]      rearm_sum;
  logic [eotq_pkg::TIME_W-1:0]    diff;
  logic [eotq_pkg::TIME_W-1:0]    delay;
  logic                           div_start;
  logic                           div_done;
  logic [eotq_pkg::SEC_W-1:0]     div_quot;
  logic [eotq_pkg::MIN_W-1:0]     div_rem;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign full      = (count == CNT_W'(CAPACITY));
  assign head_due  = (count != '0) && (cell_data[0].expire <= now_reg) && !cell_data[0].fresh;
  assign can_fire  = head_due && (nres != eotq_pkg::RES_W'(eotq_pkg::MAX_RESULTS));
  assign rearm_sum = {1'b0, now_reg} + {1'b0, cell_data[0].interval};
  assign diff      = (cell_data[0].expire > now_reg) ? cell_data[0].expire - now_reg : '0;
  assign delay     = (diff < {{(eotq_pkg::TIME_W - eotq_pkg::MIN_W){1'b0}}, min_delay}) ?
                     {{(eotq_pkg::TIME_W - eotq_pkg::MIN_W){1'b0}}, min_delay} : diff;
  assign div_start = (state == S_DPREP) && (count != '0);

  always_comb begin
    ctrl.op    = eotq_pkg::CELL_HOLD;
    ctrl.entry = rearm_entry;
    unique case (state)
      S_IDLE: begin
        ctrl.entry.fresh    = 1'b0;
        ctrl.entry.expire   = req.expire_time;
        ctrl.entry.interval = req.repeat_interval;
        ctrl.entry.ident    = req.timer_ident;
        if (accept && !req.kind && !full) ctrl.op = eotq_pkg::CELL_INSERT;
      end
      S_WALK:  ctrl.op = can_fire ? eotq_pkg::CELL_POP : eotq_pkg::CELL_CLEAR;
      S_REARM: ctrl.op = eotq_pkg::CELL_INSERT;
      default: ;
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    eotq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (CNT_W'(g) < count),
      .left_data  ((g == 0) ? ctrl.entry : cell_data[(g == 0) ? 0 : g - 1]),
      .left_after ((g == 0) ? 1'b0 : cell_after[(g == 0) ? 0 : g - 1]),
      .right_data (cell_data[(g == CAPACITY - 1) ? g : g + 1]),
      .data       (cell_data[g]),
      .after      (cell_after[g])
    );
  end

  eotq_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (delay),
    .done     (div_done),
    .quot     (div_quot),
    .rem_out  (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      min_delay <= eotq_pkg::MIN_DEFAULT;
      rsp.valid <= 1'b0;
      nres      <= '0;
      emit_idx  <= '0;
    end else begin
      if (cfg_we) min_delay <= cfg_data;
      if (rsp.ready && state != S_EMIT) rsp.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            now_reg <= req.now_time;
            if (req.kind) begin
              nres  <= '0;
              state <= S_WALK;
            end else begin
              res_buf[0] <= '{code: full ? eotq_pkg::RC_FULL : eotq_pkg::RC_ADDED,
                              ident: req.timer_ident, rearm: 1'b0};
              nres  <= eotq_pkg::RES_W'(1);
              if (!full) count <= count + 1'b1;
              state <= S_DPREP;
            end
          end
        end
        S_WALK: begin
          if (can_fire) begin
            res_buf[nres[eotq_pkg::RIDX_W-1:0]] <= '{code: eotq_pkg::RC_FIRED,
                ident: cell_data[0].ident, rearm: cell_data[0].interval != '0};
            nres  <= nres + 1'b1;
            count <= count - 1'b1;
            rearm_entry.fresh    <= 1'b1;
            rearm_entry.expire   <= rearm_sum[eotq_pkg::TIME_W] ? eotq_pkg::TIME_MAX :
                                    rearm_sum[eotq_pkg::TIME_W-1:0];
            rearm_entry.interval <= cell_data[0].interval;
            rearm_entry.ident    <= cell_data[0].ident;
            if (cell_data[0].interval != '0) state <= S_REARM;
          end else begin
            if (nres == '0) begin
              res_buf[0] <= '{code: eotq_pkg::RC_NONE, ident: '0, rearm: 1'b0};
              nres <= eotq_pkg::RES_W'(1);
            end
            state <= S_DPREP;
          end
        end
        S_REARM: begin
          count <= count + 1'b1;
          state <= S_WALK;
        end
        S_DPREP: begin
          empty_reg <= (count == '0);
          emit_idx  <= '0;
          if (count == '0) begin
            sec_reg  <= '0;
            nsec_reg <= '0;
            state    <= S_EMIT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            sec_reg  <= div_quot;
            nsec_reg <= div_rem;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.result_code <= res_buf[emit_idx[eotq_pkg::RIDX_W-1:0]].code;
            rsp.fired_ident <= res_buf[emit_idx[eotq_pkg::RIDX_W-1:0]].ident;
            rsp.was_rearmed <= res_buf[emit_idx[eotq_pkg::RIDX_W-1:0]].rearm;
            rsp.queue_empty <= empty_reg;
            emit_idx        <= emit_idx + 1'b1;
            if (emit_idx == nres - 1'b1) begin
              rsp.last       <= 1'b1;
              rsp.delay_sec  <= sec_reg;
              rsp.delay_nsec <= nsec_reg;
              state          <= S_IDLE;
            end else begin
              rsp.last       <= 1'b0;
              rsp.delay_sec  <= '0;
              rsp.delay_nsec <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- tb/timer_queue_checker.sv -----
// Watches the request and response channels of the timer queue, predicts every result
// from its own copy of the timer table, and counts mismatches. Depends on eotq_pkg, eotq_if.
`timescale 1ns / 1ps
module timer_queue_checker (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_we,
  input  wire [eotq_pkg::MIN_W-1:0] cfg_data,
  eotq_req_if                       req,
  eotq_rsp_if                       rsp,
  output int                        fails,
  output int                        waiting,
  output int                        fired_seen
);
  import eotq_pkg::*;

  localparam int SLOTS = 16;
  localparam logic [63:0] BILLION = 64'd1000000000;

  typedef struct {
    result_code_t       code;
    logic [IDENT_W-1:0] ident;
    logic               rearm;
    logic               empty;
    logic [SEC_W-1:0]   sec;
    logic [MIN_W-1:0]   nsec;
    logic               last;
  } timer_result_t;

  logic [TIME_W-1:0]  tab_exp [SLOTS];
  logic [TIME_W-1:0]  tab_ivl [SLOTS];
  logic [IDENT_W-1:0] tab_id  [SLOTS];
  int                 tab_len;
  logic [MIN_W-1:0]   floor_ns;
  timer_result_t      expected_results[$];

  function automatic void table_insert(logic [TIME_W-1:0] e, logic [TIME_W-1:0] iv,
                                       logic [IDENT_W-1:0] id);
    int pos;
    pos = 0;
    if (tab_len >= SLOTS) return;
    while (pos < tab_len && tab_exp[pos] <= e) pos++;
    for (int i = tab_len; i > pos; i--) begin
      tab_exp[i] = tab_exp[i-1];
      tab_ivl[i] = tab_ivl[i-1];
      tab_id[i]  = tab_id[i-1];
    end
    tab_exp[pos] = e;
    tab_ivl[pos] = iv;
    tab_id[pos]  = id;
    tab_len++;
  endfunction

  task automatic predict_timer_word(logic k, logic [TIME_W-1:0] now, logic [TIME_W-1:0] e,
                                    logic [TIME_W-1:0] iv, logic [IDENT_W-1:0] id);
    timer_result_t      batch[$];
    timer_result_t      r;
    logic [TIME_W-1:0]  f_ivl[$];
    logic [IDENT_W-1:0] f_id[$];
    logic [63:0]        d, sum;
    int                 cnt;
    r = '{RC_NONE, '0, 1'b0, 1'b0, '0, '0, 1'b0};
    if (!k) begin
      if (tab_len >= SLOTS) begin
        r.code = RC_FULL;
      end else begin
        table_insert(e, iv, id);
        r.code = RC_ADDED;
      end
      r.ident = id;
      batch.push_back(r);
    end else begin
      cnt = 0;
      while (cnt < tab_len && cnt < MAX_RESULTS && tab_exp[cnt] <= now) begin
        f_ivl.push_back(tab_ivl[cnt]);
        f_id.push_back(tab_id[cnt]);
        cnt++;
      end
      for (int i = 0; i + cnt < tab_len; i++) begin
        tab_exp[i] = tab_exp[i+cnt];
        tab_ivl[i] = tab_ivl[i+cnt];
        tab_id[i]  = tab_id[i+cnt];
      end
      tab_len -= cnt;
      for (int i = 0; i < cnt; i++) begin
        r.code  = RC_FIRED;
        r.ident = f_id[i];
        r.rearm = f_ivl[i] != '0;
        if (r.rearm) begin
          sum = {1'b0, now} + {1'b0, f_ivl[i]};
          table_insert(sum[63] ? TIME_MAX : sum[TIME_W-1:0], f_ivl[i], f_id[i]);
        end
        batch.push_back(r);
      end
      if (cnt == 0) batch.push_back(r);
    end
    foreach (batch[i]) batch[i].empty = tab_len == 0;
    if (tab_len != 0) begin
      d = tab_exp[0] > now ? {1'b0, tab_exp[0]} - {1'b0, now} : 64'd0;
      if (d < {34'd0, floor_ns}) d = {34'd0, floor_ns};
      batch[$].sec  = SEC_W'(d / BILLION);
      batch[$].nsec = MIN_W'(d % BILLION);
    end
    batch[$].last = 1'b1;
    foreach (batch[i]) expected_results.push_back(batch[i]);
  endtask

  always @(posedge clk) begin
    timer_result_t want;
    if (rst) begin
      tab_len = 0;
      floor_ns = MIN_DEFAULT;
      expected_results.delete();
      fails <= 0;
      fired_seen <= 0;
    end else begin
      if (cfg_we) floor_ns = cfg_data;
      if (req.valid && req.ready)
        predict_timer_word(req.kind, req.now_time, req.expire_time, req.repeat_interval,
                           req.timer_ident);
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          if (fails < 10) $display("unexpected word code=%0d ident=%0d", rsp.result_code,
                                   rsp.fired_ident);
          fails <= fails + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.code == RC_FIRED) fired_seen <= fired_seen + 1;
          if (rsp.result_code != want.code || rsp.fired_ident != want.ident ||
              rsp.was_rearmed != want.rearm || rsp.queue_empty != want.empty ||
              rsp.delay_sec != want.sec || rsp.delay_nsec != want.nsec ||
              rsp.last != want.last) begin
            if (fails < 10)
              $display("mismatch exp code=%0d id=%0d re=%0d em=%0d s=%0d ns=%0d l=%0d | %s",
                       want.code, want.ident, want.rearm, want.empty, want.sec, want.nsec,
                       want.last, $sformatf("got %0d %0d %0d %0d %0d %0d %0d",
                       rsp.result_code, rsp.fired_ident, rsp.was_rearmed, rsp.queue_empty,
                       rsp.delay_sec, rsp.delay_nsec, rsp.last));
            fails <= fails + 1;
          end
        end
      end
    end
    waiting <= expected_results.size();
  end
endmodule

// ----- tb/expiry_ordered_timer_queue_tb.sv -----
// Top of the timer queue testbench: clock, reset, stimulus, receiver stalls and verdict.
// Depends on eotq_pkg, eotq_if, timer_queue_checker and the block itself.
`timescale 1ns / 1ps
module expiry_ordered_timer_queue_tb;
  import eotq_pkg::*;

  localparam int LIMIT = 600000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [MIN_W-1:0] cfg_data = '0;
  int               fails, waiting, fired_seen;
  int               cycles = 0;
  int               words_sent = 0;
  int               burst_left = 0;
  logic             hold_tog = 1'b0;
  logic             hold_seen = 1'b0;
  int               hold_cnt = 0;
  int               rx_mode = 0;
  logic [TIME_W-1:0] clock_ns = '0;

  eotq_req_if req ();
  eotq_rsp_if rsp ();

  expiry_ordered_timer_queue dut (.clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
                                  .req(req), .rsp(rsp));

  timer_queue_checker chk (.clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
                           .req(req), .rsp(rsp), .fails(fails), .waiting(waiting),
                           .fired_seen(fired_seen));

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: long hold on request, otherwise one of four ready patterns, picked at random
  always @(posedge clk) begin
    if (cycles % 64 == 0) rx_mode <= $urandom_range(0, 3);
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_cnt <= 400;
      rsp.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      rsp.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= 1'($urandom_range(0, 1));
        2: rsp.ready <= $urandom_range(0, 3) == 0;
        default: rsp.ready <= $urandom_range(0, 7) != 0;
      endcase
    end
  end

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  task automatic send_word(logic k, logic [TIME_W-1:0] now, logic [TIME_W-1:0] e,
                           logic [TIME_W-1:0] iv, logic [IDENT_W-1:0] id);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    req.valid <= 1'b1;
    req.kind <= k;
    req.now_time <= now;
    req.expire_time <= e;
    req.repeat_interval <= iv;
    req.timer_ident <= id;
    do @(posedge clk); while (!req.ready);
    burst_left--;
    words_sent++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (waiting != 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_floor(logic [MIN_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int n);
    logic [TIME_W-1:0] iv;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(1'($urandom_range(0, 1)), rand_time(), rand_time(), rand_time(),
                  IDENT_W'($urandom));
      end else if ($urandom_range(0, 2) != 0) begin
        iv = $urandom_range(0, 2) == 0 ? '0 : TIME_W'($urandom_range(1, 3000000));
        send_word(1'b0, clock_ns, clock_ns + TIME_W'($urandom_range(0, 2500000)), iv,
                  IDENT_W'($urandom));
      end else begin
        clock_ns = clock_ns + TIME_W'($urandom_range(0, 1500000));
        send_word(1'b1, clock_ns, rand_time(), rand_time(), IDENT_W'($urandom));
      end
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.kind = 1'b0;
    req.now_time = '0;
    req.expire_time = '0;
    req.repeat_interval = '0;
    req.timer_ident = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, ties, full table, saturating re-arm
    send_word(1'b1, '0, '0, '0, '0);
    send_word(1'b0, '0, TIME_MAX, '0, 8'd0);
    send_word(1'b0, '0, 63'd500, TIME_MAX, 8'd255);
    send_word(1'b0, '0, 63'd500, 63'd7, 8'd1);
    send_word(1'b0, TIME_MAX, 63'd10, 63'd0, 8'd2);
    send_word(1'b1, 63'd500, '0, '0, '0);
    for (int i = 0; i < 14; i++)
      send_word(1'b0, 63'd600, 63'd3000000000 + TIME_W'(i % 3), TIME_W'(i % 2), 8'(i + 16));
    send_word(1'b0, 63'd600, 63'd1, 63'd1, 8'hAA);
    send_word(1'b1, TIME_MAX, '0, '0, '0);
    send_word(1'b1, TIME_MAX - 63'd5, '0, '0, '0);
    send_word(1'b1, TIME_MAX, '0, '0, '0);
    drain();

    write_floor('0);
    clock_ns = '0;
    for (int i = 0; i < 16; i++) send_word(1'b1, TIME_MAX, '0, '0, '0);
    drain();
    random_phase(90);
    drain();

    write_floor(MIN_W'(1000000000));
    hold_tog <= ~hold_tog;
    random_phase(90);
    drain();

    write_floor(MIN_W'($urandom_range(0, 1000000000)));
    random_phase(60);
    drain();
    write_floor(MIN_W'(0));
    random_phase(10);
    drain();

    $display("covered %0d words with %0d firings across four delay floors,", words_sent,
             fired_seen);
    $display("including a full table, equal expirations and a long receiver hold");
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
